FILE: hw/rtl/cs_pkg.sv
package cs_pkg;

  localparam int DATA_W             = 8;
  localparam int COUNT_W            = 7;
  localparam int MAX_ITEMS_DEFAULT  = 64;
  localparam int VALUE_BITS_DEFAULT = 8;

endpackage

FILE: hw/rtl/cs_in_if.sv
interface cs_in_if;
  import cs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

FILE: hw/rtl/cs_out_if.sv
interface cs_out_if;
  import cs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     final_res;
  logic                     overflow;

  modport source (output valid, output sorted_value, output final_res, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_res, input overflow,
                  output ready);
endinterface

FILE: hw/rtl/counting_sort_top.sv
// Channel   Modport  Payload                               Request
// in_ch     sink     value, last                           one integer of the set
// out_ch    source   sorted_value, final_res, overflow     one sorted integer
//
// A counted request reads its histogram slot, then writes it back plus one; dropped ones skip it.
// The request marked last starts a walk from the smallest to the largest value seen: each value
// in that range is read and cleared, its count latched, then emitted once per count while the
// output register is free. After reset all 2**VALUE_BITS slots are cleared before in_ch is ready.
// The output register lets the next set load while the final result is still waiting.
module counting_sort_top #(
  parameter int MAX_ITEMS  = cs_pkg::MAX_ITEMS_DEFAULT,
  parameter int VALUE_BITS = cs_pkg::VALUE_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  cs_in_if.sink     in_ch,
  cs_out_if.source  out_ch
);
  import cs_pkg::*;

  localparam int VB     = VALUE_BITS;
  localparam int W      = (VB > DATA_W) ? VB : DATA_W;
  localparam int HELD_W = $clog2(MAX_ITEMS + 1);
  localparam logic [VB-1:0]        SIGN_MASK = VB'(1) << (VB - 1);
  localparam logic signed [VB-1:0] VAL_MAX   = signed'(~SIGN_MASK);
  localparam logic signed [VB-1:0] VAL_MIN   = signed'(SIGN_MASK);

  localparam logic [2:0] ST_CLEAR     = 3'd0;
  localparam logic [2:0] ST_IDLE      = 3'd1;
  localparam logic [2:0] ST_LOAD_WR   = 3'd2;
  localparam logic [2:0] ST_WALK_RD   = 3'd3;
  localparam logic [2:0] ST_WALK_GET  = 3'd4;
  localparam logic [2:0] ST_WALK_EMIT = 3'd5;

  logic [2:0]              state;
  logic [VB-1:0]           clr_addr;
  logic signed [VB-1:0]    smallest;
  logic signed [VB-1:0]    largest;
  logic [HELD_W-1:0]       held;
  logic                    dropped;
  logic                    set_last;
  logic [VB-1:0]           load_slot;
  logic signed [VB-1:0]    x;
  logic [COUNT_W-1:0]      cnt;
  logic                    out_valid;
  logic signed [DATA_W-1:0] out_value;
  logic                    out_final;
  logic                    out_ovf;

  logic [W-1:0]            raw_w;
  logic signed [VB-1:0]    in_v;
  logic [VB-1:0]           in_slot;
  logic [VB-1:0]           x_slot;
  logic signed [W-1:0]     x_w;
  logic                    in_take;
  logic                    out_free;
  logic                    emit;

  logic                    ram_we;
  logic [VB-1:0]           ram_waddr;
  logic [COUNT_W-1:0]      ram_wdata;
  logic [VB-1:0]           ram_raddr;
  logic [COUNT_W-1:0]      ram_rdata;

  assign raw_w    = W'($unsigned(in_ch.value));
  assign in_v     = signed'(raw_w[VB-1:0]);
  assign in_slot  = raw_w[VB-1:0] ^ SIGN_MASK;
  assign x_slot   = $unsigned(x) ^ SIGN_MASK;
  assign x_w      = W'(x);
  assign in_take  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;
  assign emit     = (state == ST_WALK_EMIT) && (cnt != '0) && out_free;

  assign in_ch.ready         = (state == ST_IDLE);
  assign out_ch.valid        = out_valid;
  assign out_ch.sorted_value = out_value;
  assign out_ch.final_res    = out_final;
  assign out_ch.overflow     = out_ovf;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    ram_raddr = in_slot;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_LOAD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = load_slot;
        ram_wdata = ram_rdata + COUNT_W'(1);
      end
      ST_WALK_RD: begin
        ram_we    = 1'b1;
        ram_waddr = x_slot;
        ram_raddr = x_slot;
      end
      default: begin
      end
    endcase
  end

  cs_hist_ram #(
    .VALUE_BITS(VALUE_BITS)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      smallest  <= VAL_MAX;
      largest   <= VAL_MIN;
      held      <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        out_value <= x_w[DATA_W-1:0];
        out_final <= (cnt == COUNT_W'(1)) && (x == largest);
        out_ovf   <= dropped;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + VB'(1);
          if (clr_addr == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_take) begin
            set_last  <= in_ch.last;
            load_slot <= in_slot;
            if (held < HELD_W'(MAX_ITEMS)) begin
              held <= held + HELD_W'(1);
              if (in_v < smallest) begin
                smallest <= in_v;
              end
              if (in_v > largest) begin
                largest <= in_v;
              end
              state <= ST_LOAD_WR;
            end else begin
              dropped <= 1'b1;
              if (in_ch.last) begin
                x     <= smallest;
                state <= ST_WALK_RD;
              end
            end
          end
        end
        ST_LOAD_WR: begin
          if (set_last) begin
            x     <= smallest;
            state <= ST_WALK_RD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_WALK_RD: begin
          state <= ST_WALK_GET;
        end
        ST_WALK_GET: begin
          cnt   <= ram_rdata;
          state <= ST_WALK_EMIT;
        end
        ST_WALK_EMIT: begin
          if (cnt == '0) begin
            if (x == largest) begin
              smallest <= VAL_MAX;
              largest  <= VAL_MIN;
              held     <= '0;
              dropped  <= 1'b0;
              state    <= ST_IDLE;
            end else begin
              x     <= x + VB'(1);
              state <= ST_WALK_RD;
            end
          end else if (emit) begin
            cnt <= cnt - COUNT_W'(1);
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end
endmodule

FILE: hw/rtl/cs_hist_ram.sv
module cs_hist_ram #(
  parameter int VALUE_BITS = cs_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [VALUE_BITS-1:0]      waddr,
  input  logic [cs_pkg::COUNT_W-1:0] wdata,
  input  logic [VALUE_BITS-1:0]      raddr,
  output logic [cs_pkg::COUNT_W-1:0] rdata
);
  import cs_pkg::*;

  localparam int DEPTH = 1 << VALUE_BITS;

  logic [COUNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cs_pkg::*;

  localparam int MAX_ITEMS    = MAX_ITEMS_DEFAULT;
  localparam int VALUE_BITS   = VALUE_BITS_DEFAULT;
  localparam int HIST_DEPTH   = 1 << VALUE_BITS;
  localparam int VAL_MIN      = -(HIST_DEPTH / 2);
  localparam int VAL_MAX      = HIST_DEPTH / 2 - 1;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 3 * HIST_DEPTH + MAX_ITEMS + 200;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
    logic                     overflow;
  } sorted_item_t;

  class sort_scoreboard;
    int unsigned  tally[HIST_DEPTH];
    int           low_seen;
    int           high_seen;
    int           held;
    bit           dropped;
    sorted_item_t sorted_q[$];
    int           mismatches;

    function new();
      mismatches = 0;
      clear_set();
    endfunction

    function void clear_set();
      foreach (tally[i]) tally[i] = 0;
      low_seen  = VAL_MAX;
      high_seen = VAL_MIN;
      held      = 0;
      dropped   = 1'b0;
    endfunction

    function int slot_of(int x);
      return (x - VAL_MIN) & (HIST_DEPTH - 1);
    endfunction

    function void note_request(logic signed [DATA_W-1:0] v, logic l);
      int           x;
      int           c;
      int           n;
      sorted_item_t r;
      x = int'(v) & (HIST_DEPTH - 1);
      if (x >= HIST_DEPTH / 2) x -= HIST_DEPTH;
      if (held < MAX_ITEMS) begin
        tally[slot_of(x)] = (tally[slot_of(x)] + 1) & ((1 << COUNT_W) - 1);
        if (x < low_seen) low_seen = x;
        if (x > high_seen) high_seen = x;
        held++;
      end else begin
        dropped = 1'b1;
      end
      if (!l) return;
      n = 0;
      if (held > 0) begin
        for (int y = low_seen; y <= high_seen; y++) begin
          c = tally[slot_of(y)];
          while (c > 0 && n < MAX_ITEMS) begin
            r.sorted_value = DATA_W'(y);
            r.final_res    = 1'b0;
            r.overflow     = dropped;
            sorted_q.push_back(r);
            n++;
            c--;
          end
        end
        if (n > 0) sorted_q[sorted_q.size() - 1].final_res = 1'b1;
      end
      clear_set();
    endfunction

    function void check_result(logic signed [DATA_W-1:0] sv, logic fr, logic ov);
      sorted_item_t r;
      if (sorted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: value %0d final %0b overflow %0b", sv, fr, ov);
        return;
      end
      r = sorted_q.pop_front();
      if (r.sorted_value !== sv || r.final_res !== fr || r.overflow !== ov) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: expected value %0d final %0b overflow %0b, got %0d %0b %0b",
                   r.sorted_value, r.final_res, r.overflow, sv, fr, ov);
      end
    endfunction

    function int pending();
      return sorted_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   in_burst;
  bit   out_burst;
  int   idle_cycles;
  int   items_sent;

  sort_scoreboard sb;

  cs_in_if  in_ch ();
  cs_out_if out_ch ();

  counting_sort_top DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_item(input logic signed [DATA_W-1:0] v, input logic l);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= l;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(v, l);
    items_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic send_random_set(input int size);
    int                       mode;
    logic signed [DATA_W-1:0] base;
    logic signed [DATA_W-1:0] v;
    mode = $urandom_range(0, 2);
    base = DATA_W'($urandom_range(0, 255));
    for (int i = 0; i < size; i++) begin
      case (mode)
        0: begin
          v = base + DATA_W'($urandom_range(0, 3));
        end
        1: begin
          v = ($urandom_range(0, 1) != 0) ? DATA_W'(VAL_MAX) : DATA_W'(VAL_MIN);
          if ($urandom_range(0, 1) != 0) v = DATA_W'($urandom_range(0, 255));
        end
        default: begin
          v = DATA_W'($urandom_range(0, 255));
        end
      endcase
      send_item(v, i == size - 1);
    end
  endtask

  initial begin
    out_ch.ready = 1'b0;
    out_burst    = 1'b0;
    @(negedge rst);
    forever begin
      int stall;
      if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 19);
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_result(out_ch.sorted_value, out_ch.final_res, out_ch.overflow);
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int set_no;
    int size;
    sb          = new();
    items_sent  = 0;
    in_burst    = 1'b0;
    rst         = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.last  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(8'sd0, 1'b1);
    send_item(-8'sd128, 1'b1);
    send_item(8'sd127, 1'b1);
    send_item(8'sd127, 1'b0);
    send_item(-8'sd128, 1'b1);
    send_item(8'sd5, 1'b0);
    send_item(-8'sd1, 1'b0);
    send_item(8'sd5, 1'b0);
    send_item(8'sd5, 1'b0);
    send_item(-8'sd1, 1'b1);
    send_item(-8'sd1, 1'b0);
    send_item(8'sd1, 1'b0);
    send_item(8'sd0, 1'b0);
    send_item(-8'sd128, 1'b0);
    send_item(8'sd127, 1'b0);
    send_item(-8'sd64, 1'b0);
    send_item(8'sd63, 1'b0);
    send_item(8'sd85, 1'b0);
    send_item(-8'sd86, 1'b1);
    wait_for_results();

    set_no = 0;
    while (items_sent < 100 || set_no < 4) begin
      in_burst = ($urandom_range(0, 3) == 0);
      if (set_no == 2) begin
        size = MAX_ITEMS + $urandom_range(1, 4);
      end else if ($urandom_range(0, 3) == 0) begin
        size = $urandom_range(8, 20);
      end else begin
        size = $urandom_range(1, 6);
      end
      send_random_set(size);
      if ($urandom_range(0, 4) == 0) wait_for_results();
      set_no++;
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
